// ===== sv/lsps_pkg.sv =====
// Shared constants, types and the reciprocal table of the line sensor PID steering block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lsps_pkg;

    localparam int NUM_LANES   = 5;
    localparam int SAMPLE_W    = 12;
    localparam int SCALE_W     = 10;
    localparam int DUTY_W      = 11;
    localparam int POS_W       = 9;
    localparam int GAIN_W      = 8;
    localparam int GAIN_FRAC   = 4;
    localparam int WSUM_W      = 10;
    localparam int CNT_W       = 3;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int ERR_W       = 10;
    localparam int LERR_W      = 9;
    localparam int INTEG_W     = 16;
    localparam int OPD_W       = 17;
    localparam int DIFF_W      = 11;
    localparam int ACC_W       = 26;
    localparam int LIM_SUM_W   = 18;
    localparam int LIM_W       = 14;
    localparam int PID_W       = 15;
    localparam int NUM_W       = 24;
    localparam int DEN_W       = 15;
    localparam int QUO_W       = 9;
    localparam int QBIT_W      = $clog2(QUO_W);
    localparam int MAG_W       = 9;
    localparam int DUTY_SHIFT  = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    localparam int LANE_STEP       = 100;
    localparam int MID_DUTY        = 250;
    localparam int FULL_SPAN       = 500;
    localparam int LIM_K_PD        = 200;
    localparam int LIM_K_I         = 600;
    localparam int TARGET_POSITION = 200;
    localparam int LERR_MAX        = 255;
    localparam int LERR_MIN        = -256;

    localparam logic signed [ERR_W-1:0] TARGET_POS_S = ERR_W'(TARGET_POSITION);

    localparam logic [SAMPLE_W-1:0] THR_RST [NUM_LANES] =
        '{12'd1000, 12'd1000, 12'd3400, 12'd2200, 12'd2200};
    localparam logic [GAIN_W-1:0] GAIN_P_RST = 8'd16;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 8'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR0   = 3'd0,
        CFG_THR1   = 3'd1,
        CFG_THR2   = 3'd2,
        CFG_THR3   = 3'd3,
        CFG_THR4   = 3'd4,
        CFG_GAIN_P = 3'd5,
        CFG_GAIN_I = 3'd6,
        CFG_GAIN_D = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic divide;
    } t_merge_ctl;

    typedef struct packed {
        logic             line_seen;
        logic [POS_W-1:0] position;
    } t_merge_res;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    // ceil(2^16 / count); exact for sums up to 1000 after the shift
    function automatic logic [RECIP_W-1:0] f_recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        case (cnt)
            3'd1:    r = 17'd65536;
            3'd2:    r = 17'd32768;
            3'd3:    r = 17'd21846;
            3'd4:    r = 17'd16384;
            3'd5:    r = 17'd13108;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/lsps_if.sv =====
// Request and result channel interfaces of the line sensor PID steering block.
// Depends on lsps_pkg for field widths.
`timescale 1ns / 1ps

interface lsps_req_if import lsps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_s0;
    logic [SAMPLE_W-1:0] sample_s1;
    logic [SAMPLE_W-1:0] sample_s2;
    logic [SAMPLE_W-1:0] sample_s3;
    logic [SAMPLE_W-1:0] sample_s4;
    logic [SCALE_W-1:0]  speed_scale;

    modport source (output valid, sample_s0, sample_s1, sample_s2, sample_s3, sample_s4,
                    speed_scale, input ready);
    modport sink   (input valid, sample_s0, sample_s1, sample_s2, sample_s3, sample_s4,
                    speed_scale, output ready);
endinterface

interface lsps_rsp_if import lsps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              line_seen;
    logic [POS_W-1:0]  line_position;

    modport source (output valid, left_duty, right_duty, line_seen, line_position,
                    input ready);
    modport sink   (input valid, left_duty, right_duty, line_seen, line_position,
                    output ready);
endinterface

// ===== sv/lsps_lane.sv =====
// One sensor lane: threshold compare and position weight of that sensor.
// Depends on lsps_pkg.
`timescale 1ns / 1ps

module lsps_lane import lsps_pkg::*; (
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SAMPLE_W-1:0] i_threshold,
    input  logic [CNT_W-1:0]    i_lane_idx,
    output logic                o_hit,
    output logic [POS_W-1:0]    o_weight
);

    logic [POS_W-1:0] w_step;

    assign o_hit    = (i_sample < i_threshold);
    assign w_step   = POS_W'(i_lane_idx) * POS_W'(LANE_STEP);
    assign o_weight = o_hit ? w_step : '0;

endmodule

// ===== sv/lsps_merge.sv =====
// Merging stage: sums lane weights and hits, then divides by the hit count
// through a reciprocal multiply. Depends on lsps_pkg.
`timescale 1ns / 1ps

module lsps_merge import lsps_pkg::*; (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_merge_ctl                       i_ctl,
    input  logic [NUM_LANES-1:0]             i_hit,
    input  logic [NUM_LANES-1:0][POS_W-1:0]  i_weight,
    output t_merge_res                       o_res
);

    logic [WSUM_W-1:0]         n_sum, r_sum;
    logic [CNT_W-1:0]          n_cnt, r_cnt;
    logic [POS_W-1:0]          r_pos;
    logic [WSUM_W+RECIP_W-1:0] w_prod;

    always_comb begin
        n_sum = '0;
        n_cnt = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            n_sum = n_sum + WSUM_W'(i_weight[k]);
            n_cnt = n_cnt + CNT_W'(i_hit[k]);
        end
    end

    assign w_prod = (WSUM_W+RECIP_W)'(r_sum) * (WSUM_W+RECIP_W)'(f_recip(r_cnt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sum <= n_sum;
        end
        if (i_ctl.divide) begin
            r_pos <= w_prod[RECIP_SHIFT +: POS_W];
        end
    end

    assign o_res.line_seen = (r_cnt != '0);
    assign o_res.position  = r_pos;

endmodule

// ===== sv/lsps_div.sv =====
// Restoring divider, one quotient bit per cycle, for quotients below 2^QUO_W.
// Depends on lsps_pkg.
`timescale 1ns / 1ps

module lsps_div import lsps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [QBIT_W-1:0] r_bit;
    logic [NUM_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_quo;
    logic [NUM_W-1:0]  w_trial;
    logic              w_fits;

    assign w_trial = NUM_W'(r_den) << r_bit;
    assign w_fits  = (r_rem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= r_busy && (r_bit == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_bit  <= QBIT_W'(QUO_W - 1);
            end else if (r_busy) begin
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_bit <= r_bit - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy && w_fits) begin
            r_rem        <= r_rem - w_trial;
            r_quo[r_bit] <= 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== sv/line_sensor_pid_steering.sv =====
// Line sensor PID steering top level: lanes, merge stage, PID sequencer; needs lsps_pkg,
// lsps_if, lsps_lane, lsps_merge and lsps_div.
// One request at a time, taken only in S_IDLE; it passes S_POS, S_ERR, S_MUL_P, S_MUL_I,
// S_MUL_D (one shared multiplier), S_CLAMP, S_NUM, S_DIV (serial divider), S_DUTY_L,
// S_DUTY_R and S_DONE. All gains zero skip S_DIV; no line seen goes from S_POS to S_DONE.
// Reset (i_rst_n low, synchronous) loads default thresholds and gains, clears state.
`timescale 1ns / 1ps

module line_sensor_pid_steering import lsps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lsps_req_if.sink              i_req,
    lsps_rsp_if.source            o_rsp
);

    // Sequencer states, one-hot
    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_POS    = 12'b0000_0000_0010,
        S_ERR    = 12'b0000_0000_0100,
        S_MUL_P  = 12'b0000_0000_1000,
        S_MUL_I  = 12'b0000_0001_0000,
        S_MUL_D  = 12'b0000_0010_0000,
        S_CLAMP  = 12'b0000_0100_0000,
        S_NUM    = 12'b0000_1000_0000,
        S_DIV    = 12'b0001_0000_0000,
        S_DUTY_L = 12'b0010_0000_0000,
        S_DUTY_R = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [SAMPLE_W-1:0] r_thr [NUM_LANES];
    logic [GAIN_W-1:0]   r_gain_p, r_gain_i, r_gain_d;

    // Controller state kept across requests
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [LERR_W-1:0]  r_le;
    logic [DUTY_W-1:0]         r_held_left, r_held_right;
    logic [POS_W-1:0]          r_held_pos;

    // Per-request working registers
    logic [SCALE_W-1:0]       r_scale;
    logic signed [ERR_W-1:0]  r_e;
    logic signed [DIFF_W-1:0] r_d;
    logic [LIM_W-1:0]         r_lim;
    logic signed [ACC_W-1:0]  r_acc;
    logic [PID_W-1:0]         r_pid;
    logic [QUO_W-1:0]         r_q;

    // Output register
    logic              r_out_valid;
    logic [DUTY_W-1:0] r_out_left, r_out_right;
    logic              r_out_seen;
    logic [POS_W-1:0]  r_out_pos;

    logic                            w_req_acc;
    logic                            w_out_free;
    logic [SAMPLE_W-1:0]             w_sample [NUM_LANES];
    logic [NUM_LANES-1:0]            w_hit;
    logic [NUM_LANES-1:0][POS_W-1:0] w_weight;
    t_merge_ctl                      w_merge_ctl;
    t_merge_res                      w_merge_res;
    t_div_req                        w_div_req;
    t_div_rsp                        w_div_rsp;

    //------------------------------------------------------------------
    // Handshakes: take a request only while idle; the output register
    // holds a finished result so the next request can come in meanwhile.
    //------------------------------------------------------------------
    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    //------------------------------------------------------------------
    // Configuration writes
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_thr[k] <= THR_RST[k];
            end
            r_gain_p <= GAIN_P_RST;
            r_gain_i <= GAIN_I_RST;
            r_gain_d <= GAIN_D_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THR0:   r_thr[0] <= i_cfg_data;
                CFG_THR1:   r_thr[1] <= i_cfg_data;
                CFG_THR2:   r_thr[2] <= i_cfg_data;
                CFG_THR3:   r_thr[3] <= i_cfg_data;
                CFG_THR4:   r_thr[4] <= i_cfg_data;
                CFG_GAIN_P: r_gain_p <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I: r_gain_i <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D: r_gain_d <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Sensor lanes work straight off the request payload; the merge stage
    // registers sum and count at acceptance, then the position in S_POS.
    //------------------------------------------------------------------
    assign w_sample[0] = i_req.sample_s0;
    assign w_sample[1] = i_req.sample_s1;
    assign w_sample[2] = i_req.sample_s2;
    assign w_sample[3] = i_req.sample_s3;
    assign w_sample[4] = i_req.sample_s4;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        lsps_lane u_lane (
            .i_sample    (w_sample[g]),
            .i_threshold (r_thr[g]),
            .i_lane_idx  (CNT_W'(g)),
            .o_hit       (w_hit[g]),
            .o_weight    (w_weight[g])
        );
    end

    assign w_merge_ctl.load   = w_req_acc;
    assign w_merge_ctl.divide = (r_state == S_POS);

    lsps_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_merge_ctl),
        .i_hit    (w_hit),
        .i_weight (w_weight),
        .o_res    (w_merge_res)
    );

    //------------------------------------------------------------------
    // Error, integral and derivative (S_ERR)
    //------------------------------------------------------------------
    logic signed [ERR_W-1:0]   w_e;
    logic [ERR_W-1:0]          w_abs_e, w_abs_le;
    logic signed [ERR_W-1:0]   w_le_x;
    logic signed [INTEG_W:0]   w_isum;
    logic signed [INTEG_W-1:0] w_integ_n;
    logic signed [LERR_W-1:0]  w_le_sat;
    logic signed [DIFF_W-1:0]  w_d;
    logic [LIM_SUM_W-1:0]      w_lim_sum;

    always_comb begin
        w_e      = $signed({1'b0, w_merge_res.position}) - TARGET_POS_S;
        w_abs_e  = w_e[ERR_W-1] ? ERR_W'(-w_e) : ERR_W'(w_e);
        w_le_x   = $signed({r_le[LERR_W-1], r_le});
        w_abs_le = w_le_x[ERR_W-1] ? ERR_W'(-w_le_x) : ERR_W'(w_le_x);

        // Accumulate while the error is not shrinking, else restart at the error
        w_isum = $signed({r_integ[INTEG_W-1], r_integ})
               + $signed({{(INTEG_W+1-ERR_W){w_e[ERR_W-1]}}, w_e});
        if (w_abs_le <= w_abs_e) begin
            if (w_isum[INTEG_W] != w_isum[INTEG_W-1]) begin
                w_integ_n = w_isum[INTEG_W] ? $signed({1'b1, {(INTEG_W-1){1'b0}}})
                                            : $signed({1'b0, {(INTEG_W-1){1'b1}}});
            end else begin
                w_integ_n = w_isum[INTEG_W-1:0];
            end
        end else begin
            w_integ_n = $signed({{(INTEG_W-ERR_W){w_e[ERR_W-1]}}, w_e});
        end

        if (w_e > LERR_MAX) begin
            w_le_sat = LERR_W'(LERR_MAX);
        end else if (w_e < LERR_MIN) begin
            w_le_sat = LERR_W'(LERR_MIN);
        end else begin
            w_le_sat = w_e[LERR_W-1:0];
        end

        w_d = $signed({w_e[ERR_W-1], w_e})
            - $signed({{(DIFF_W-LERR_W){r_le[LERR_W-1]}}, r_le});

        w_lim_sum = LIM_SUM_W'(r_gain_p) * LIM_SUM_W'(LIM_K_PD)
                  + LIM_SUM_W'(r_gain_i) * LIM_SUM_W'(LIM_K_I)
                  + LIM_SUM_W'(r_gain_d) * LIM_SUM_W'(LIM_K_PD);
    end

    //------------------------------------------------------------------
    // Shared multiplier: one gain product per state, accumulated in r_acc
    //------------------------------------------------------------------
    logic [GAIN_W-1:0]       w_mul_gain;
    logic signed [OPD_W-1:0] w_mul_opd;
    logic signed [ACC_W-1:0] w_prod;

    always_comb begin
        if (r_state == S_MUL_P) begin
            w_mul_gain = r_gain_p;
            w_mul_opd  = $signed({{(OPD_W-ERR_W){r_e[ERR_W-1]}}, r_e});
        end else if (r_state == S_MUL_I) begin
            w_mul_gain = r_gain_i;
            w_mul_opd  = $signed({{(OPD_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ});
        end else begin
            w_mul_gain = r_gain_d;
            w_mul_opd  = $signed({{(OPD_W-DIFF_W){r_d[DIFF_W-1]}}, r_d});
        end
        w_prod = $signed({{(ACC_W-GAIN_W){1'b0}}, w_mul_gain})
               * $signed({{(ACC_W-OPD_W){w_mul_opd[OPD_W-1]}}, w_mul_opd});
    end

    //------------------------------------------------------------------
    // Scale to Q0 with truncation toward zero, clamp to +/- lim (S_CLAMP)
    //------------------------------------------------------------------
    logic signed [ACC_W-1:0] w_acc_b, w_pid_full, w_lim_s, w_pid_clamp;

    always_comb begin
        w_acc_b    = r_acc + $signed({{(ACC_W-GAIN_FRAC){1'b0}},
                                      {GAIN_FRAC{r_acc[ACC_W-1]}}});
        w_pid_full = w_acc_b >>> GAIN_FRAC;
        w_lim_s    = $signed({{(ACC_W-LIM_W){1'b0}}, r_lim});
        if (w_pid_full > w_lim_s) begin
            w_pid_clamp = w_lim_s;
        end else if (w_pid_full < -w_lim_s) begin
            w_pid_clamp = -w_lim_s;
        end else begin
            w_pid_clamp = w_pid_full;
        end
    end

    //------------------------------------------------------------------
    // Map to 0..500 through the serial divider (S_NUM, S_DIV)
    //------------------------------------------------------------------
    logic [PID_W-1:0] w_ofs;
    logic [NUM_W-1:0] w_num;

    // pid + lim is never negative, so modular add gives the true value
    assign w_ofs = r_pid + PID_W'(r_lim);
    assign w_num = NUM_W'(w_ofs) * NUM_W'(FULL_SPAN);

    assign w_div_req.start = (r_state == S_NUM) && (r_lim != '0);
    assign w_div_req.num   = w_num;
    assign w_div_req.den   = {r_lim, 1'b0};

    lsps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    //------------------------------------------------------------------
    // Duties: r_q is pwm + 250; one side runs at mid duty, the other
    // steers. Scale by the Q2.8 speed factor, one side per state.
    //------------------------------------------------------------------
    logic [MAG_W-1:0]         w_left_mag, w_right_mag, w_duty_opd;
    logic [MAG_W+SCALE_W-1:0] w_duty_prod;
    logic [DUTY_W-1:0]        w_duty;

    always_comb begin
        if (r_e[ERR_W-1] || (r_e == '0)) begin
            w_left_mag = MAG_W'(MID_DUTY);
        end else begin
            w_left_mag = MAG_W'(FULL_SPAN) - r_q;
        end
        w_right_mag = r_e[ERR_W-1] ? r_q : MAG_W'(MID_DUTY);
        w_duty_opd  = (r_state == S_DUTY_L) ? w_left_mag : w_right_mag;
        w_duty_prod = (MAG_W+SCALE_W)'(w_duty_opd) * (MAG_W+SCALE_W)'(r_scale);
        w_duty      = w_duty_prod[DUTY_SHIFT +: DUTY_W];
    end

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_req_acc) n_state = S_POS;
            // no line seen: skip all updates and repeat the held result
            S_POS:    n_state = w_merge_res.line_seen ? S_ERR : S_DONE;
            S_ERR:    n_state = S_MUL_P;
            S_MUL_P:  n_state = S_MUL_I;
            S_MUL_I:  n_state = S_MUL_D;
            S_MUL_D:  n_state = S_CLAMP;
            S_CLAMP:  n_state = S_NUM;
            // all gains zero: lim is zero, take pwm as zero and skip the divider
            S_NUM:    n_state = (r_lim == '0) ? S_DUTY_L : S_DIV;
            S_DIV:    if (w_div_rsp.done) n_state = S_DUTY_L;
            S_DUTY_L: n_state = S_DUTY_R;
            S_DUTY_R: n_state = S_DONE;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_integ      <= '0;
            r_le         <= '0;
            r_held_left  <= '0;
            r_held_right <= '0;
            r_held_pos   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ERR) begin
                r_integ    <= w_integ_n;
                r_le       <= w_le_sat;
                r_held_pos <= w_merge_res.position;
            end
            if (r_state == S_DUTY_L) begin
                r_held_left <= w_duty;
            end
            if (r_state == S_DUTY_R) begin
                r_held_right <= w_duty;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_scale <= i_req.speed_scale;
        end
        if (r_state == S_ERR) begin
            r_e   <= w_e;
            r_d   <= w_d;
            r_lim <= w_lim_sum[GAIN_FRAC +: LIM_W];
        end
        if (r_state == S_MUL_P) begin
            r_acc <= w_prod;
        end else if (r_state == S_MUL_I || r_state == S_MUL_D) begin
            r_acc <= r_acc + w_prod;
        end
        if (r_state == S_CLAMP) begin
            r_pid <= w_pid_clamp[PID_W-1:0];
        end
        if (r_state == S_NUM && r_lim == '0) begin
            r_q <= QUO_W'(MID_DUTY);
        end else if (r_state == S_DIV && w_div_rsp.done) begin
            r_q <= w_div_rsp.quo;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_left  <= r_held_left;
            r_out_right <= r_held_right;
            r_out_seen  <= w_merge_res.line_seen;
            r_out_pos   <= r_held_pos;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.left_duty     = r_out_left;
    assign o_rsp.right_duty    = r_out_right;
    assign o_rsp.line_seen     = r_out_seen;
    assign o_rsp.line_position = r_out_pos;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> r_out_valid)
        else $error("finished result did not reach the output register");

    a_quotient_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUTY_L) |-> (r_q <= QUO_W'(FULL_SPAN)))
        else $error("steering quotient above full span");

    a_no_line_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS && !w_merge_res.line_seen) |=>
        ($stable(r_held_left) && $stable(r_held_right) && $stable(r_integ)))
        else $error("state changed on a request with no line seen");

    a_last_err_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ERR) |=> $stable(r_le))
        else $error("last error changed outside the error step");

endmodule

// ===== dv/tb_line_sensor_pid_steering.sv =====
// Self-checking regression for line_sensor_pid_steering: drives sensor requests, predicts
// steering results with an in-bench model and checks them in order.
// Depends on lsps_pkg, lsps_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_line_sensor_pid_steering;
    import lsps_pkg::*;

    localparam int CLK_HALF_NS    = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_LIMIT     = 3000;   // far beyond hold-off plus the time to finish one request
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 40;
    localparam int MAX_PRINTS     = 60;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
    localparam int SCALE_MAX      = (1 << SCALE_W) - 1;
    localparam int GAIN_MAX       = (1 << GAIN_W) - 1;
    localparam int GAIN_ONE       = 1 << GAIN_FRAC;
    localparam int INTEG_MAX      = (1 << (INTEG_W - 1)) - 1;
    localparam int INTEG_MIN      = -(1 << (INTEG_W - 1));
    localparam int NUM_REGS       = 8;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_FRAMES   = 110;

    typedef struct packed {
        logic [NUM_LANES-1:0][SAMPLE_W-1:0] sample;
        logic [SCALE_W-1:0]                 scale;
    } t_sensor_frame;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              line_seen;
        logic [POS_W-1:0]  position;
    } t_steer_cmd;

    typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] t_cfg_image;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lsps_req_if req_ch ();
    lsps_rsp_if rsp_ch ();

    line_sensor_pid_steering dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Steering results still owed by the block, oldest first.
    t_steer_cmd expected_steering [$];
    int         mismatch_count = 0;
    int         idle_cycles = 0;

    // Pacing knobs shared by the tests, the request sender and the result sink.
    int src_gap_max = 0;
    int burst_left = 0;
    int sink_stall_pct = 0;
    int holdoff_request = 0;

    // Shadow copy of the block's registers and controller state.
    int               thr_shadow [NUM_LANES];
    int               kp_shadow, ki_shadow, kd_shadow;
    int               integ_shadow, last_err_shadow;
    logic [DUTY_W-1:0] held_left_shadow, held_right_shadow;
    logic [POS_W-1:0]  held_pos_shadow;

    function automatic void reset_shadow();
        int lane;
        for (lane = 0; lane < NUM_LANES; lane++) begin
            thr_shadow[lane] = int'(THR_RST[lane]);
        end
        kp_shadow = int'(GAIN_P_RST);
        ki_shadow = int'(GAIN_I_RST);
        kd_shadow = int'(GAIN_D_RST);
        integ_shadow = 0;
        last_err_shadow = 0;
        held_left_shadow = '0;
        held_right_shadow = '0;
        held_pos_shadow = '0;
    endfunction

    function automatic int abs_int(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clip(input int v, input int lo, input int hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic [DUTY_W-1:0] scaled_duty(input int x, input int scale);
        int u;
        u = (x < 0) ? 0 : x;
        return DUTY_W'((u * scale) >> DUTY_SHIFT);
    endfunction

    // Advance the shadow controller by one accepted request and return the steering result.
    function automatic t_steer_cmd predict_steering(input t_sensor_frame f);
        int lane, pos_sum, seen, err, diff, g, pid, lim, pwm, lft, rgt;
        t_steer_cmd cmd;
        pos_sum = 0;
        seen = 0;
        for (lane = 0; lane < NUM_LANES; lane++) begin
            if (int'(f.sample[lane]) < thr_shadow[lane]) begin
                pos_sum += lane * LANE_STEP;
                seen++;
            end
        end
        cmd.line_seen = (seen != 0);
        if (seen != 0) begin
            held_pos_shadow = POS_W'(pos_sum / seen);
            err = int'(held_pos_shadow) - TARGET_POSITION;
            // keep accumulating while the error is not shrinking, else restart at the error
            if (abs_int(last_err_shadow) <= abs_int(err)) begin
                integ_shadow = clip(integ_shadow + err, INTEG_MIN, INTEG_MAX);
            end else begin
                integ_shadow = clip(err, INTEG_MIN, INTEG_MAX);
            end
            diff = err - last_err_shadow;
            last_err_shadow = clip(err, LERR_MIN, LERR_MAX);
            g = kp_shadow * err + ki_shadow * integ_shadow + kd_shadow * diff;
            pid = g / GAIN_ONE;     // int division truncates toward zero
            lim = (LIM_K_PD * kp_shadow + LIM_K_I * ki_shadow + LIM_K_PD * kd_shadow) / GAIN_ONE;
            if (lim == 0) begin
                pwm = 0;
            end else begin
                pid = clip(pid, -lim, lim);
                pwm = (pid + lim) * FULL_SPAN / (2 * lim) - MID_DUTY;
            end
            lft = MID_DUTY;
            rgt = MID_DUTY;
            if (err < 0) begin
                rgt = MID_DUTY + pwm;
            end else if (err > 0) begin
                lft = MID_DUTY - pwm;
            end
            held_left_shadow = scaled_duty(lft, int'(f.scale));
            held_right_shadow = scaled_duty(rgt, int'(f.scale));
        end
        cmd.left_duty = held_left_shadow;
        cmd.right_duty = held_right_shadow;
        cmd.position = held_pos_shadow;
        return cmd;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    function automatic t_sensor_frame make_frame(input int s0, s1, s2, s3, s4, input int scale);
        t_sensor_frame f;
        f.sample[0] = SAMPLE_W'(s0);
        f.sample[1] = SAMPLE_W'(s1);
        f.sample[2] = SAMPLE_W'(s2);
        f.sample[3] = SAMPLE_W'(s3);
        f.sample[4] = SAMPLE_W'(s4);
        f.scale = SCALE_W'(scale);
        return f;
    endfunction

    // Only one lane sees the line (sample 0), every other lane reads full white.
    function automatic t_sensor_frame make_lane_frame(input int lane, input int scale);
        t_sensor_frame f;
        int k;
        for (k = 0; k < NUM_LANES; k++) begin
            f.sample[k] = (k == lane) ? '0 : SAMPLE_W'(SAMPLE_MAX);
        end
        f.scale = SCALE_W'(scale);
        return f;
    endfunction

    // Mostly a plausible line under one to three adjacent lanes, with some random lane
    // sets, some frames off the line and some raw noise.
    function automatic t_sensor_frame random_frame();
        t_sensor_frame f;
        int kind, lane, first, width, thr;
        logic [NUM_LANES-1:0] on_line;
        kind = $urandom_range(0, 99);
        f.scale = SCALE_W'($urandom_range(0, SCALE_MAX));
        if (kind < 15) begin
            for (lane = 0; lane < NUM_LANES; lane++) begin
                f.sample[lane] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            end
            return f;
        end
        if (kind < 25) begin
            on_line = '0;
        end else if (kind < 75) begin
            first = $urandom_range(0, NUM_LANES - 1);
            width = $urandom_range(1, 3);
            on_line = '0;
            for (lane = first; lane < NUM_LANES && lane < first + width; lane++) begin
                on_line[lane] = 1'b1;
            end
        end else begin
            on_line = NUM_LANES'($urandom_range(1, (1 << NUM_LANES) - 1));
        end
        for (lane = 0; lane < NUM_LANES; lane++) begin
            thr = thr_shadow[lane];
            if (on_line[lane] && thr > 0) begin
                f.sample[lane] = SAMPLE_W'($urandom_range(0, thr - 1));
            end else if (on_line[lane]) begin
                f.sample[lane] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            end else begin
                f.sample[lane] = SAMPLE_W'($urandom_range(thr, SAMPLE_MAX));
            end
        end
        return f;
    endfunction

    function automatic t_cfg_image default_image();
        t_cfg_image img;
        int lane;
        for (lane = 0; lane < NUM_LANES; lane++) begin
            img[lane] = CFG_DATA_W'(THR_RST[lane]);
        end
        img[CFG_GAIN_P] = CFG_DATA_W'(GAIN_P_RST);
        img[CFG_GAIN_I] = CFG_DATA_W'(GAIN_I_RST);
        img[CFG_GAIN_D] = CFG_DATA_W'(GAIN_D_RST);
        return img;
    endfunction

    // Write every register, one per clock, and mirror it. Call only with the block idle.
    task automatic program_config(input t_cfg_image img);
        int idx;
        t_cfg_idx reg_sel;
        for (idx = 0; idx < NUM_REGS; idx++) begin
            reg_sel = t_cfg_idx'(idx);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= reg_sel;
            i_cfg_data <= img[idx];
            @(posedge i_clk);
            case (reg_sel)
                CFG_GAIN_P: kp_shadow = int'(img[idx]) & GAIN_MAX;
                CFG_GAIN_I: ki_shadow = int'(img[idx]) & GAIN_MAX;
                CFG_GAIN_D: kd_shadow = int'(img[idx]) & GAIN_MAX;
                default:    thr_shadow[idx] = int'(img[idx]);
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offer one request, idling between bursts; return once the block has taken it.
    task automatic send_frame(input t_sensor_frame f);
        int gap;
        if (burst_left == 0) begin
            gap = (src_gap_max > 0) ? $urandom_range(0, src_gap_max) : 0;
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req_ch.valid <= 1'b1;
        req_ch.sample_s0 <= f.sample[0];
        req_ch.sample_s1 <= f.sample[1];
        req_ch.sample_s2 <= f.sample[2];
        req_ch.sample_s3 <= f.sample[3];
        req_ch.sample_s4 <= f.sample[4];
        req_ch.speed_scale <= f.scale;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_steering.push_back(predict_steering(f));
        burst_left--;
    endtask

    // Drop valid and wait for every owed result, so registers may be rewritten.
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (expected_steering.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result sink pacing: random runs of ready and stall, plus an optional long hold-off.
    initial begin : sink_pacing
        int run_left;
        int hold_left;
        bit stalling;
        run_left = 0;
        hold_left = 0;
        stalling = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_request > 0) begin
                hold_left = holdoff_request;
                holdoff_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    stalling = ($urandom_range(0, 99) < sink_stall_pct);
                    run_left = $urandom_range(1, 8);
                end
                run_left--;
                rsp_ch.ready <= !stalling;
            end
        end
    end

    // Compare each accepted result with the oldest prediction, field by field.
    always @(posedge i_clk) begin
        t_steer_cmd want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_steering.size() == 0) begin
                report_mismatch("result with no request pending", int'(rsp_ch.left_duty), 0);
            end else begin
                want = expected_steering.pop_front();
                if (rsp_ch.left_duty !== want.left_duty)
                    report_mismatch("left_duty", int'(rsp_ch.left_duty), int'(want.left_duty));
                if (rsp_ch.right_duty !== want.right_duty)
                    report_mismatch("right_duty", int'(rsp_ch.right_duty), int'(want.right_duty));
                if (rsp_ch.line_seen !== want.line_seen)
                    report_mismatch("line_seen", int'(rsp_ch.line_seen), int'(want.line_seen));
                if (rsp_ch.line_position !== want.position)
                    report_mismatch("line_position", int'(rsp_ch.line_position),
                                    int'(want.position));
            end
        end
    end

    // Watchdog: end the run when neither channel nor the register port moves for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("line_sensor_pid_steering regression: fail");
            $finish;
        end
    end

    // Reset settings: center, off-line hold, each lane alone, threshold edges, speed edges.
    task automatic test_directed_edges();
        int lane;
        src_gap_max = 3;
        sink_stall_pct = 30;
        // every lane on the line averages to dead center
        send_frame(make_frame(0, 0, 0, 0, 0, 256));
        // nothing seen: repeat the held drive and position
        send_frame(make_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 256));
        for (lane = 0; lane < NUM_LANES; lane++) begin
            send_frame(make_lane_frame(lane, 128 + 200 * lane));
            send_frame(make_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                                  SCALE_MAX));
        end
        // a sample equal to its threshold is not line; one below is
        send_frame(make_frame(THR_RST[0], THR_RST[1], THR_RST[2], THR_RST[3], THR_RST[4], 300));
        send_frame(make_frame(THR_RST[0], THR_RST[1] - 1, THR_RST[2], THR_RST[3], THR_RST[4],
                              300));
        // pairs land between lanes; truncated averages across three
        send_frame(make_frame(0, 0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 256));
        send_frame(make_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0, 0, 256));
        send_frame(make_frame(0, SAMPLE_MAX, SAMPLE_MAX, 0, 0, 512));
        // speed scale extremes
        send_frame(make_lane_frame(4, 0));
        send_frame(make_lane_frame(0, SCALE_MAX));
        send_frame(make_frame(0, 0, 0, 0, SAMPLE_MAX, SCALE_MAX));
    endtask

    // All gains zero: no steering limit, both duties at mid scale, state still advances.
    task automatic test_zero_gains();
        t_cfg_image img;
        settle_block();
        img = default_image();
        img[CFG_GAIN_P] = '0;
        img[CFG_GAIN_I] = '0;
        img[CFG_GAIN_D] = '0;
        program_config(img);
        send_frame(make_lane_frame(0, 256));
        send_frame(make_lane_frame(4, SCALE_MAX));
        send_frame(make_lane_frame(2, 77));
        send_frame(make_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0));
        // back to the defaults: the saved integral and error carry into the first steered request
        settle_block();
        program_config(default_image());
        send_frame(make_lane_frame(3, 256));
    endtask

    // Hold the error at full right, then full left, so the integral pins at both rails.
    task automatic test_integral_saturation();
        t_cfg_image img;
        int n;
        settle_block();
        src_gap_max = 0;
        sink_stall_pct = 10;
        img = default_image();
        img[CFG_GAIN_P] = CFG_DATA_W'(1);
        img[CFG_GAIN_I] = CFG_DATA_W'(GAIN_MAX);
        img[CFG_GAIN_D] = '0;
        program_config(img);
        for (n = 0; n < 180; n++) begin
            send_frame(make_lane_frame(NUM_LANES - 1, $urandom_range(0, SCALE_MAX)));
        end
        for (n = 0; n < 350; n++) begin
            send_frame(make_lane_frame(0, $urandom_range(0, SCALE_MAX)));
        end
    endtask

    // Phases of random settings (extremes mixed in) with random requests in each.
    task automatic test_random_configs();
        t_cfg_image img;
        int phase, idx, pick, gain, n;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle_block();
            for (idx = 0; idx < NUM_REGS; idx++) begin
                pick = $urandom_range(0, 3);
                if (idx < NUM_LANES) begin
                    if (phase == 0) img[idx] = CFG_DATA_W'(SAMPLE_MAX);
                    else if (phase == 1) img[idx] = '0;
                    else if (pick == 0) img[idx] = '0;
                    else if (pick == 1) img[idx] = CFG_DATA_W'(SAMPLE_MAX);
                    else img[idx] = CFG_DATA_W'($urandom_range(0, SAMPLE_MAX));
                end else begin
                    if (phase == 0) gain = GAIN_MAX;
                    else if (pick == 0) gain = 0;
                    else if (pick == 1) gain = GAIN_MAX;
                    else gain = $urandom_range(0, GAIN_MAX);
                    // junk above the gain width must be dropped by the block
                    img[idx] = CFG_DATA_W'(($urandom_range(0, 15) << GAIN_W) | gain);
                end
            end
            program_config(img);
            src_gap_max = (phase % 3 == 0) ? 0 : $urandom_range(2, 10);
            sink_stall_pct = (phase % 4 == 2) ? 0 : $urandom_range(10, 60);
            for (n = 0; n < PHASE_FRAMES; n++) begin
                send_frame(random_frame());
            end
        end
    endtask

    // Hold the result sink off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        int n;
        settle_block();
        program_config(default_image());
        src_gap_max = 0;
        sink_stall_pct = 0;
        holdoff_request = HOLDOFF_CYCLES;
        for (n = 0; n < 40; n++) begin
            send_frame(random_frame());
        end
        sink_stall_pct = 40;
        src_gap_max = 5;
        for (n = 0; n < 40; n++) begin
            send_frame(random_frame());
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_THR0;
        i_cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.sample_s0 <= '0;
        req_ch.sample_s1 <= '0;
        req_ch.sample_s2 <= '0;
        req_ch.sample_s3 <= '0;
        req_ch.sample_s4 <= '0;
        req_ch.speed_scale <= '0;
        reset_shadow();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_zero_gains();
        test_integral_saturation();
        test_random_configs();
        test_backpressure();

        // drain, then give any stray result time to show up
        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_steering.size() != 0) begin
            report_mismatch("results never delivered", 0, expected_steering.size());
        end
        if (mismatch_count == 0) begin
            $display("line_sensor_pid_steering regression: pass");
        end else begin
            $display("line_sensor_pid_steering regression: fail");
        end
        $finish;
    end

endmodule
